// File: rtl/wall_clock_keeper_with_persist_top_defines.svh
// ----------------------------------------------------------------------------
// Wall-clock keeper assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef WALL_CLOCK_KEEPER_WITH_PERSIST_TOP_DEFINES_SVH
`define WALL_CLOCK_KEEPER_WITH_PERSIST_TOP_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define WCKP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wall clock keeper check failed");

// Next-cycle implication, checked outside of reset.
`define WCKP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wall clock keeper check failed");

`endif

// File: rtl/wckp_pkg.sv
// ----------------------------------------------------------------------------
// Wall-clock keeper package
// Types, codes, reset values and helper functions shared by the block.
// ----------------------------------------------------------------------------
package wckp_pkg;

    // Default parameter values.
    localparam int WCKP_RATE_LOG2 = 3;
    localparam int WCKP_TICK_BITS = 48;

    // Register reset values.
    localparam logic [31:0] RST_MIN_EPOCH         = 32'd1704067200;
    localparam logic [31:0] RST_MAX_EPOCH         = 32'd4102444800;
    localparam logic [23:0] RST_PERSIST_INTERVAL  = 24'd2400;
    localparam logic [15:0] RST_MIN_PERSIST_DELTA = 16'd30;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_MIN_EPOCH         = 2'd0;
    localparam logic [1:0] REG_MAX_EPOCH         = 2'd1;
    localparam logic [1:0] REG_PERSIST_INTERVAL  = 2'd2;
    localparam logic [1:0] REG_MIN_PERSIST_DELTA = 2'd3;

    // Item function codes.
    typedef enum logic [2:0] {
        FN_TICK    = 3'd0,
        FN_SYNC    = 3'd1,
        FN_RESTORE = 3'd2,
        FN_FORCE   = 3'd3,
        FN_CONVERT = 3'd4
    } t_func;

    // Clock status codes.
    typedef enum logic [1:0] {
        ST_UNKNOWN = 2'd0,
        ST_STALE   = 2'd1,
        ST_FRESH   = 2'd2
    } t_status;

    // Configuration register set.
    typedef struct packed {
        logic [31:0] min_epoch;
        logic [31:0] max_epoch;
        logic [23:0] persist_interval;
        logic [15:0] min_persist_delta;
    } t_cfg;

    // One input item.
    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] epoch_value;
        logic [47:0] query_ticks;
    } t_item;

    // True when the epoch lies inside the configured range.
    function automatic logic in_range(input t_cfg cfg, input logic [31:0] e);
        return (e >= cfg.min_epoch) && (e <= cfg.max_epoch);
    endfunction

    // Absolute difference of two epochs.
    function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

// File: rtl/wckp_cfg.sv
// ----------------------------------------------------------------------------
// Wall-clock keeper configuration registers
// APB-style register file holding the epoch range and the persist settings.
// ----------------------------------------------------------------------------
module wckp_cfg
    import wckp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    // Register writes on the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_epoch         <= RST_MIN_EPOCH;
            r_cfg.max_epoch         <= RST_MAX_EPOCH;
            r_cfg.persist_interval  <= RST_PERSIST_INTERVAL;
            r_cfg.min_persist_delta <= RST_MIN_PERSIST_DELTA;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MIN_EPOCH:         r_cfg.min_epoch         <= pwdata;
                REG_MAX_EPOCH:         r_cfg.max_epoch         <= pwdata;
                REG_PERSIST_INTERVAL:  r_cfg.persist_interval  <= pwdata[23:0];
                REG_MIN_PERSIST_DELTA: r_cfg.min_persist_delta <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read data mux.
    always_comb begin
        case (reg_idx)
            REG_MIN_EPOCH:         prdata = r_cfg.min_epoch;
            REG_MAX_EPOCH:         prdata = r_cfg.max_epoch;
            REG_PERSIST_INTERVAL:  prdata = {8'd0, r_cfg.persist_interval};
            REG_MIN_PERSIST_DELTA: prdata = {16'd0, r_cfg.min_persist_delta};
            default:               prdata = 32'd0;
        endcase
    end

endmodule

// File: rtl/wckp_in_reg.sv
// ----------------------------------------------------------------------------
// Wall-clock keeper input register
// Captures one item per cycle while the stage is free and holds it until the core takes it.
// ----------------------------------------------------------------------------
module wckp_in_reg
    import wckp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [2:0]  i_func,
    input  logic [31:0] i_epoch_value,
    input  logic [47:0] i_query_ticks,
    input  logic        i_take,
    output logic        o_ready,
    output logic        o_valid,
    output t_item       o_item
);

    logic  r_valid;
    t_item r_item;

    // The stage is free when empty or when its item leaves this cycle.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Item payload.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.func        <= i_func;
            r_item.epoch_value <= i_epoch_value;
            r_item.query_ticks <= i_query_ticks;
        end
    end

endmodule

// File: rtl/wckp_core.sv
// ----------------------------------------------------------------------------
// Wall-clock keeper core
// Clock state, combinational item update and the result register.
// ----------------------------------------------------------------------------
module wckp_core
    import wckp_pkg::*;
#(
    parameter int RATE_LOG2 = WCKP_RATE_LOG2,
    parameter int TICK_BITS = WCKP_TICK_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_in_valid,
    input  t_item       i_item,
    output logic        o_take,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_current_epoch,
    output logic [1:0]  o_time_state,
    output logic [31:0] o_secs_since_sync,
    output logic [31:0] o_uptime_secs,
    output logic        o_persist_write,
    output logic [31:0] o_persist_epoch,
    output logic [31:0] o_converted_epoch
);

    // Whole seconds from one tick count to a later one; zero if it lies before.
    function automatic logic [31:0] elapsed(input logic [TICK_BITS-1:0] now,
                                            input logic [TICK_BITS-1:0] from);
        logic [TICK_BITS-1:0] d;
        d = (now >= from) ? (now - from) : '0;
        return 32'(d >> RATE_LOG2);
    endfunction

    // Clock state.
    logic [TICK_BITS-1:0] r_tick, n_tick;
    logic [TICK_BITS-1:0] r_base_ticks, n_base_ticks;
    logic [31:0]          r_base_epoch, n_base_epoch;
    logic [TICK_BITS-1:0] r_sync_ticks, n_sync_ticks;
    logic                 r_sync_seen, n_sync_seen;
    logic [31:0]          r_saved_epoch, n_saved_epoch;
    logic [TICK_BITS-1:0] r_saved_at, n_saved_at;
    t_status              r_status, n_status;

    // Result register.
    logic        r_out_valid;
    logic [31:0] r_current_epoch, n_current_epoch;
    logic [1:0]  r_time_state;
    logic [31:0] r_secs_since_sync, n_secs_since_sync;
    logic [31:0] r_uptime_secs;
    logic        r_persist_write, n_persist_write;
    logic [31:0] r_persist_epoch, n_persist_epoch;
    logic [31:0] r_converted_epoch, n_converted_epoch;

    // Working signals.
    logic                 fire;
    t_func                fn;
    logic [31:0]          ev;
    logic [TICK_BITS-1:0] q_t;
    logic [TICK_BITS-1:0] tick_inc;
    logic [TICK_BITS-1:0] tick_sel;
    logic                 known;
    logic [31:0]          e_run;
    logic                 ev_ok;
    logic                 run_ok;
    logic                 delta_ok;
    logic [31:0]          conv_fwd;
    logic [31:0]          conv_back;
    logic                 due;

    // An item is processed when the result register is free or being drained.
    assign fire   = i_in_valid && (!r_out_valid || i_ready);
    assign o_take = fire;

    assign fn       = t_func'(i_item.func);
    assign ev       = i_item.epoch_value;
    assign q_t      = TICK_BITS'(i_item.query_ticks);
    assign tick_inc = r_tick + TICK_BITS'(1);
    assign tick_sel = (fn == FN_TICK) ? tick_inc : r_tick;

    // Running epoch at the tick count this item leaves behind.
    assign known = (r_status != ST_UNKNOWN) && (r_base_epoch != 32'd0);
    assign e_run = known ? (r_base_epoch + elapsed(tick_sel, r_base_ticks)) : 32'd0;

    // Save qualification.
    assign ev_ok    = in_range(i_cfg, ev);
    assign run_ok   = in_range(i_cfg, e_run);
    assign delta_ok = (r_saved_epoch == 32'd0) ||
                      (abs_diff(e_run, r_saved_epoch) >= {16'd0, i_cfg.min_persist_delta});
    assign due      = (tick_inc - r_saved_at) >= TICK_BITS'(i_cfg.persist_interval);

    // Conversion of a query tick count on either side of the base.
    assign conv_fwd  = r_base_epoch + 32'((q_t - r_base_ticks) >> RATE_LOG2);
    assign conv_back = 32'((r_base_ticks - q_t) >> RATE_LOG2);

    // Next state and result for the item in the input register.
    always_comb begin
        n_tick            = r_tick;
        n_base_ticks      = r_base_ticks;
        n_base_epoch      = r_base_epoch;
        n_sync_ticks      = r_sync_ticks;
        n_sync_seen       = r_sync_seen;
        n_saved_epoch     = r_saved_epoch;
        n_saved_at        = r_saved_at;
        n_status          = r_status;
        n_persist_write   = 1'b0;
        n_persist_epoch   = 32'd0;
        n_converted_epoch = 32'd0;
        n_current_epoch   = e_run;
        n_secs_since_sync = r_sync_seen ? elapsed(tick_sel, r_sync_ticks) : '1;
        case (fn)
            FN_TICK: begin
                n_tick = tick_inc;
                if (due) begin
                    n_saved_at = tick_inc;
                    if (known && run_ok && delta_ok) begin
                        n_persist_write = 1'b1;
                        n_persist_epoch = e_run;
                        n_saved_epoch   = e_run;
                    end
                end
            end
            FN_SYNC: begin
                if (ev_ok) begin
                    n_base_ticks      = r_tick;
                    n_base_epoch      = ev;
                    n_sync_ticks      = r_tick;
                    n_sync_seen       = 1'b1;
                    n_status          = ST_FRESH;
                    n_persist_write   = 1'b1;
                    n_persist_epoch   = ev;
                    n_saved_epoch     = ev;
                    n_saved_at        = r_tick;
                    n_current_epoch   = ev;
                    n_secs_since_sync = 32'd0;
                end
            end
            FN_RESTORE: begin
                if ((r_status == ST_UNKNOWN) && ev_ok) begin
                    n_base_epoch    = ev;
                    n_base_ticks    = r_tick;
                    n_saved_epoch   = ev;
                    n_status        = ST_STALE;
                    n_current_epoch = ev;
                end
            end
            FN_FORCE: begin
                if (known) begin
                    n_saved_at = r_tick;
                    if (run_ok) begin
                        n_persist_write = 1'b1;
                        n_persist_epoch = e_run;
                        n_saved_epoch   = e_run;
                    end
                end
            end
            FN_CONVERT: begin
                if (known) begin
                    if (q_t >= r_base_ticks) begin
                        n_converted_epoch = conv_fwd;
                    end else begin
                        n_converted_epoch = (r_base_epoch > conv_back) ?
                                            (r_base_epoch - conv_back) : 32'd0;
                    end
                end
            end
            default: ;
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick        <= '0;
            r_base_ticks  <= '0;
            r_base_epoch  <= 32'd0;
            r_sync_ticks  <= '0;
            r_sync_seen   <= 1'b0;
            r_saved_epoch <= 32'd0;
            r_saved_at    <= '0;
            r_status      <= ST_UNKNOWN;
        end else if (fire) begin
            r_tick        <= n_tick;
            r_base_ticks  <= n_base_ticks;
            r_base_epoch  <= n_base_epoch;
            r_sync_ticks  <= n_sync_ticks;
            r_sync_seen   <= n_sync_seen;
            r_saved_epoch <= n_saved_epoch;
            r_saved_at    <= n_saved_at;
            r_status      <= n_status;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_current_epoch   <= n_current_epoch;
            r_time_state      <= n_status;
            r_secs_since_sync <= n_secs_since_sync;
            r_uptime_secs     <= 32'(n_tick >> RATE_LOG2);
            r_persist_write   <= n_persist_write;
            r_persist_epoch   <= n_persist_epoch;
            r_converted_epoch <= n_converted_epoch;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_current_epoch   = r_current_epoch;
    assign o_time_state      = r_time_state;
    assign o_secs_since_sync = r_secs_since_sync;
    assign o_uptime_secs     = r_uptime_secs;
    assign o_persist_write   = r_persist_write;
    assign o_persist_epoch   = r_persist_epoch;
    assign o_converted_epoch = r_converted_epoch;

endmodule

// File: rtl/wall_clock_keeper_with_persist_top.sv
// ----------------------------------------------------------------------------
// Wall-clock keeper with persisted epoch, top level
// An item passes the input register, then the core's result register; back-pressure can hold either.
// Throughput: one item per cycle while the result output is not stalled.
// Reset: synchronous, active low; clears the clock state and both item stages
// and loads the register reset values. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "wall_clock_keeper_with_persist_top_defines.svh"

module wall_clock_keeper_with_persist_top
    import wckp_pkg::*;
#(
    parameter int RATE_LOG2 = WCKP_RATE_LOG2,
    parameter int TICK_BITS = WCKP_TICK_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_func,
    input  logic [31:0] i_epoch_value,
    input  logic [47:0] i_query_ticks,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_current_epoch,
    output logic [1:0]  o_time_state,
    output logic [31:0] o_secs_since_sync,
    output logic [31:0] o_uptime_secs,
    output logic        o_persist_write,
    output logic [31:0] o_persist_epoch,
    output logic [31:0] o_converted_epoch
);

    t_cfg  cfg;
    t_item item;
    logic  item_valid;
    logic  take;
    logic  persist_in_range;
    logic  no_epoch;

    // Configuration registers.
    wckp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input item register.
    wckp_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_func        (i_func),
        .i_epoch_value (i_epoch_value),
        .i_query_ticks (i_query_ticks),
        .i_take        (take),
        .o_ready       (o_ready),
        .o_valid       (item_valid),
        .o_item        (item)
    );

    // Clock state and result register.
    wckp_core #(
        .RATE_LOG2 (RATE_LOG2),
        .TICK_BITS (TICK_BITS)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_in_valid        (item_valid),
        .i_item            (item),
        .o_take            (take),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_current_epoch   (o_current_epoch),
        .o_time_state      (o_time_state),
        .o_secs_since_sync (o_secs_since_sync),
        .o_uptime_secs     (o_uptime_secs),
        .o_persist_write   (o_persist_write),
        .o_persist_epoch   (o_persist_epoch),
        .o_converted_epoch (o_converted_epoch)
    );

    // Conditions used by the checks below.
    assign persist_in_range = (o_persist_epoch >= cfg.min_epoch) &&
                              (o_persist_epoch <= cfg.max_epoch);
    assign no_epoch         = (o_current_epoch == 32'd0) && (o_converted_epoch == 32'd0);

    // A requested write always carries an epoch inside the configured range.
    `WCKP_ASSERT_NOW(a_persist_in_range, o_valid && o_persist_write, persist_in_range)

    // Without a write request the stored value reads as zero.
    `WCKP_ASSERT_NOW(a_persist_idle_zero, o_valid && !o_persist_write, o_persist_epoch == 32'd0)

    // An unknown clock reports no epoch at all.
    `WCKP_ASSERT_NOW(a_unknown_no_epoch, o_valid && (o_time_state == ST_UNKNOWN), no_epoch)

    // An item taken by the core always shows up as a valid result next cycle.
    `WCKP_ASSERT_NEXT(a_take_gives_result, take, o_valid)

endmodule
